// ----- rtl/fec_pkg.sv -----
package fec_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned POLY_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GEN_POLY   = CFG_IDX_W'(1);

  localparam logic [POLY_W-1:0] GEN_POLY_RESET = 32'h04C1_1DB7;

  typedef enum logic [1:0] {
    MODE_EVEN = 2'd0,
    MODE_ODD  = 2'd1,
    MODE_CRC  = 2'd2,
    MODE_NONE = 2'd3
  } check_mode_e;

  localparam check_mode_e CHECK_MODE_RESET = MODE_CRC;

  // register contents seen by the checker
  typedef struct packed {
    check_mode_e       mode;
    logic [POLY_W-1:0] poly;
  } cfg_t;

  // input register contents
  typedef struct packed {
    logic valid;
    logic frame_bit;
    logic frame_last;
  } in_stage_t;

endpackage

// ----- rtl/fec_if.sv -----
// bit stream channel
interface fec_in_if;
  logic valid;
  logic ready;
  logic frame_bit;
  logic frame_last;

  modport source(output valid, frame_bit, frame_last, input ready);
  modport sink(input valid, frame_bit, frame_last, output ready);
endinterface

// result channel
interface fec_out_if;
  logic valid;
  logic ready;
  logic frame_error;

  modport source(output valid, frame_error, input ready);
  modport sink(input valid, frame_error, output ready);
endinterface

// register write channel
interface fec_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_idx;
  logic [31:0] wr_data;

  modport source(output valid, reg_idx, wr_data, input ready);
  modport sink(input valid, reg_idx, wr_data, output ready);
endinterface

// ----- rtl/fec_cfg_regs.sv -----
module fec_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_valid_i,
  input  logic [fec_pkg::CFG_IDX_W-1:0] wr_idx_i,
  input  logic [fec_pkg::POLY_W-1:0]  wr_data_i,
  output logic                        wr_ready_o,
  output fec_pkg::cfg_t               cfg_o
);
  import fec_pkg::*;

  check_mode_e       mode_q, mode_d;
  logic [POLY_W-1:0] poly_q, poly_d;

  // writes are always taken; unknown indexes are dropped
  assign wr_ready_o = 1'b1;

  always_comb begin
    mode_d = mode_q;
    poly_d = poly_q;
    if (wr_valid_i) begin
      case (wr_idx_i)
        REG_CHECK_MODE: mode_d = check_mode_e'(wr_data_i[1:0]);
        REG_GEN_POLY:   poly_d = wr_data_i;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= CHECK_MODE_RESET;
      poly_q <= GEN_POLY_RESET;
    end else begin
      mode_q <= mode_d;
      poly_q <= poly_d;
    end
  end

  assign cfg_o.mode = mode_q;
  assign cfg_o.poly = poly_q;

endmodule

// ----- rtl/fec_in_reg.sv -----
module fec_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic                frame_bit_i,
  input  logic                frame_last_i,
  output logic                ready_o,
  input  logic                advance_i,
  output fec_pkg::in_stage_t  stage_o
);
  import fec_pkg::*;

  logic valid_q, valid_d;
  logic bit_q, bit_d;
  logic last_q, last_d;

  // a new request may enter while the held one moves on
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    bit_d   = bit_q;
    last_d  = last_q;
    if (ready_o) begin
      valid_d = valid_i;
      bit_d   = frame_bit_i;
      last_d  = frame_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    bit_q  <= bit_d;
    last_q <= last_d;
  end

  assign stage_o.valid      = valid_q;
  assign stage_o.frame_bit  = bit_q;
  assign stage_o.frame_last = last_q;

endmodule

// ----- rtl/fec_check_core.sv -----
module fec_check_core #(
  parameter int unsigned CRC_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fec_pkg::cfg_t      cfg_i,
  input  fec_pkg::in_stage_t stage_i,
  output logic               advance_o,
  output logic               out_valid_o,
  output logic               out_error_o,
  input  logic               out_ready_i
);
  import fec_pkg::*;

  logic [CRC_WIDTH-1:0]        rem_q, rem_d, rem_step;
  logic                        par_q, par_d, par_step;
  logic                        out_valid_q, out_valid_d;
  logic                        err_q, err_d, err_now;
  logic                        out_free;
  logic [CRC_WIDTH+POLY_W-1:0] poly_wide;
  logic [CRC_WIDTH-1:0]        poly_m;

  // generator bits at or above the remainder width are dropped
  assign poly_wide = {{CRC_WIDTH{1'b0}}, cfg_i.poly};
  assign poly_m    = poly_wide[CRC_WIDTH-1:0];

  // one step of long division and parity
  assign rem_step = {rem_q[CRC_WIDTH-2:0], stage_i.frame_bit}
                    ^ (rem_q[CRC_WIDTH-1] ? poly_m : {CRC_WIDTH{1'b0}});
  assign par_step = par_q ^ stage_i.frame_bit;

  // a last bit waits only when the result register is still full
  assign out_free  = !out_valid_q || out_ready_i;
  assign advance_o = stage_i.valid && (!stage_i.frame_last || out_free);

  // error flag for the selected check
  always_comb begin
    case (cfg_i.mode)
      MODE_EVEN: err_now = par_step;
      MODE_ODD:  err_now = !par_step;
      MODE_CRC:  err_now = |rem_step;
      default:   err_now = 1'b0;
    endcase
  end

  // accumulator update, cleared at the end of each frame
  always_comb begin
    rem_d = rem_q;
    par_d = par_q;
    if (advance_o) begin
      if (stage_i.frame_last) begin
        rem_d = '0;
        par_d = 1'b0;
      end else begin
        rem_d = rem_step;
        par_d = par_step;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    err_d       = err_q;
    if (advance_o && stage_i.frame_last) begin
      out_valid_d = 1'b1;
      err_d       = err_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      par_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      par_q       <= par_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_error_o = err_q;

  // accumulators are clear after a frame ends
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_o && stage_i.frame_last) |=> (rem_q == '0 && !par_q))
    else $error("accumulators not cleared after last bit");

  // a result appears only from a last bit
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance_o && stage_i.frame_last))
    else $error("result without last bit");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_o && stage_i.frame_last) |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

endmodule

// ----- rtl/frame_error_check.sv -----
// channel | dir | payload                    | handshake
// in_i    | in  | frame_bit, frame_last      | valid / ready
// out_o   | out | frame_error                | valid / ready
// cfg_i   | in  | reg_idx (2b), wr_data (32b)| valid / ready, ready always high
//
// one bit per cycle while no last bit is held back; each bit is held in the
// input register, where the shift-and-xor remainder update and parity update
// run on it. a frame result is loaded into the result register at the edge
// its last bit leaves the input register.
// reset clears both accumulators and sets CRC mode with generator 0x04C11DB7.
// a stalled result holds back a last bit, and the input behind it; other bits
// keep flowing.
module frame_error_check #(
  parameter int unsigned CRC_WIDTH = 32
) (
  input logic    clk_i,
  input logic    rst_ni,
  fec_in_if.sink     in_i,
  fec_out_if.source  out_o,
  fec_cfg_if.sink    cfg_i
);
  import fec_pkg::*;

  cfg_t      cfg;
  in_stage_t stage;
  logic      advance;

  // register file
  fec_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_idx_i   (cfg_i.reg_idx),
    .wr_data_i  (cfg_i.wr_data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  // input register
  fec_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .frame_bit_i  (in_i.frame_bit),
    .frame_last_i (in_i.frame_last),
    .ready_o      (in_i.ready),
    .advance_i    (advance),
    .stage_o      (stage)
  );

  // accumulators and result register
  fec_check_core #(
    .CRC_WIDTH (CRC_WIDTH)
  ) u_check_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .stage_i     (stage),
    .advance_o   (advance),
    .out_valid_o (out_o.valid),
    .out_error_o (out_o.frame_error),
    .out_ready_i (out_o.ready)
  );

endmodule
